// File: hw/rtl/hsl2rgb_pkg.sv
// ============================================================================
// HSL to RGB converter package
// Number formats, derived constants and the hue sector type shared by the
// HSL to RGB conversion pipeline.
// ============================================================================
package hsl2rgb_pkg;

    // Input field width: hue, saturation and lightness are all signed.
    localparam int IN_W            = 14;

    // Fraction bits of the unit range and sub-degree bits of the hue.
    localparam int FRAC_BITS       = 12;
    localparam int HUE_SUBDEG_BITS = 4;

    // Unit value (1.0) and the width that holds 0..ONE inclusive.
    localparam int ONE             = 1 << FRAC_BITS;
    localparam int UNIT_W          = FRAC_BITS + 1;

    // One full turn and one 60 degree sector in hue units.
    localparam int HUE_FULL        = 360 << HUE_SUBDEG_BITS;
    localparam int HUE_SECT        = 60 << HUE_SUBDEG_BITS;
    localparam int HUE_W           = $clog2(HUE_FULL);
    localparam int F_W             = $clog2(HUE_SECT);
    localparam int SECT_W          = $clog2(HUE_SECT + 1);

    // Sign-extended hue width, wide enough for two turns either way.
    localparam int HX_W            = IN_W + 2;

    // Product C * f and the exact reciprocal used to divide it by a sector.
    localparam int PROD_W          = UNIT_W + SECT_W;
    localparam int RSH             = PROD_W + SECT_W;
    localparam longint unsigned RECIP =
        ((64'd1 << RSH) + longint'(HUE_SECT) - 64'd1) / longint'(HUE_SECT);
    localparam int RECIP_W         = $clog2(RECIP + 1);
    localparam int QPROD_W         = PROD_W + RECIP_W;

    // Hue sector, which decides the order of (C, X, 0) across the channels.
    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW    = 3'd0,
        SECTOR_YELLOW_GREEN  = 3'd1,
        SECTOR_GREEN_CYAN    = 3'd2,
        SECTOR_CYAN_BLUE     = 3'd3,
        SECTOR_BLUE_MAGENTA  = 3'd4,
        SECTOR_MAGENTA_RED   = 3'd5
    } hue_sector_t;

    typedef logic [UNIT_W-1:0] unit_t;

endpackage

// File: hw/rtl/hsl_to_rgb_converter.sv
// ============================================================================
// HSL to RGB converter
// Converts one HSL color per item into Q1.12 red, green and blue in a
// five-stage pipeline with per-stage valid bits and stall back-pressure.
// ============================================================================
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ---------------------------------
//  hsl      input      hsl_valid/hsl_stall  hue, saturation, lightness (s14)
//  rgb      output     rgb_valid/rgb_stall  red, green, blue (u13)
//
//  One item is taken per cycle while hsl_stall is low.
//  The chroma multiply, the C * f multiply and the reciprocal multiply that
//  divides by one sector each sit in a stage of their own.
//  A stage moves when it is empty or the stage after it moves, so bubbles
//  close up under a stall and hsl_stall is high only when all stages are full.
//  Reset empties the pipeline; the data registers are not reset.
//
module hsl_to_rgb_converter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                hsl_valid,
    output logic                                hsl_stall,
    input  logic signed [hsl2rgb_pkg::IN_W-1:0] hue,
    input  logic signed [hsl2rgb_pkg::IN_W-1:0] saturation,
    input  logic signed [hsl2rgb_pkg::IN_W-1:0] lightness,
    output logic                                rgb_valid,
    input  logic                                rgb_stall,
    output logic [hsl2rgb_pkg::UNIT_W-1:0]      red,
    output logic [hsl2rgb_pkg::UNIT_W-1:0]      green,
    output logic [hsl2rgb_pkg::UNIT_W-1:0]      blue
);

    // ------------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------------
    logic                                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                                 s4_valid_reg, s5_valid_reg;
    logic                                 s1_move, s2_move, s3_move, s4_move, s5_move;

    logic [hsl2rgb_pkg::HUE_W-1:0]        s1_hue_reg;
    hsl2rgb_pkg::unit_t                   s1_sat_reg, s1_light_reg, s1_span_reg;

    hsl2rgb_pkg::hue_sector_t             s2_sector_reg;
    logic [hsl2rgb_pkg::F_W-1:0]          s2_frac_reg;
    hsl2rgb_pkg::unit_t                   s2_chroma_reg, s2_light_reg;

    hsl2rgb_pkg::hue_sector_t             s3_sector_reg;
    logic [hsl2rgb_pkg::PROD_W-1:0]       s3_prod_reg;
    hsl2rgb_pkg::unit_t                   s3_chroma_reg, s3_offset_reg;

    hsl2rgb_pkg::hue_sector_t             s4_sector_reg;
    hsl2rgb_pkg::unit_t                   s4_x_reg, s4_chroma_reg, s4_offset_reg;

    hsl2rgb_pkg::unit_t                   s5_red_reg, s5_green_reg, s5_blue_reg;

    // Next values
    logic [hsl2rgb_pkg::HUE_W-1:0]        s1_hue_next;
    hsl2rgb_pkg::unit_t                   s1_sat_next, s1_light_next, s1_span_next;
    hsl2rgb_pkg::hue_sector_t             s2_sector_next;
    logic [hsl2rgb_pkg::F_W-1:0]          s2_frac_next;
    hsl2rgb_pkg::unit_t                   s2_chroma_next;
    logic [hsl2rgb_pkg::PROD_W-1:0]       s3_prod_next;
    hsl2rgb_pkg::unit_t                   s3_offset_next;
    hsl2rgb_pkg::unit_t                   s4_x_next;
    hsl2rgb_pkg::unit_t                   s5_red_next, s5_green_next, s5_blue_next;

    // ------------------------------------------------------------------------
    // Flow control: a stage moves when it is empty or its successor moves.
    // ------------------------------------------------------------------------
    assign s5_move   = !s5_valid_reg || !rgb_stall;
    assign s4_move   = !s4_valid_reg || s5_move;
    assign s3_move   = !s3_valid_reg || s4_move;
    assign s2_move   = !s2_valid_reg || s3_move;
    assign s1_move   = !s1_valid_reg || s2_move;
    assign hsl_stall = !s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_move) s1_valid_reg <= hsl_valid;
            if (s2_move) s2_valid_reg <= s1_valid_reg;
            if (s3_move) s3_valid_reg <= s2_valid_reg;
            if (s4_move) s4_valid_reg <= s3_valid_reg;
            if (s5_move) s5_valid_reg <= s4_valid_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: wrap the hue into one turn, clamp S and L, form 1 - |2L - 1|.
    // ------------------------------------------------------------------------
    always_comb
    begin
        logic signed [hsl2rgb_pkg::HX_W-1:0] hue_x;
        logic signed [hsl2rgb_pkg::HX_W-1:0] hue_w;
        logic [hsl2rgb_pkg::UNIT_W:0]        light2;
        logic [hsl2rgb_pkg::UNIT_W:0]        light_dev;

        hue_x = hsl2rgb_pkg::HX_W'(hue);
        if (hue_x < -hsl2rgb_pkg::HUE_FULL)
            hue_w = hue_x + hsl2rgb_pkg::HX_W'(2 * hsl2rgb_pkg::HUE_FULL);
        else if (hue_x < 0)
            hue_w = hue_x + hsl2rgb_pkg::HX_W'(hsl2rgb_pkg::HUE_FULL);
        else if (hue_x >= hsl2rgb_pkg::HUE_FULL)
            hue_w = hue_x - hsl2rgb_pkg::HX_W'(hsl2rgb_pkg::HUE_FULL);
        else
            hue_w = hue_x;
        s1_hue_next = hue_w[hsl2rgb_pkg::HUE_W-1:0];

        // Clamp saturation and lightness to 0..ONE.
        if (saturation < 0)
            s1_sat_next = '0;
        else if (saturation > hsl2rgb_pkg::ONE)
            s1_sat_next = hsl2rgb_pkg::UNIT_W'(hsl2rgb_pkg::ONE);
        else
            s1_sat_next = saturation[hsl2rgb_pkg::UNIT_W-1:0];

        if (lightness < 0)
            s1_light_next = '0;
        else if (lightness > hsl2rgb_pkg::ONE)
            s1_light_next = hsl2rgb_pkg::UNIT_W'(hsl2rgb_pkg::ONE);
        else
            s1_light_next = lightness[hsl2rgb_pkg::UNIT_W-1:0];

        // Distance of 2L from one, then its complement.
        light2 = {s1_light_next, 1'b0};
        if (light2 >= (hsl2rgb_pkg::UNIT_W + 1)'(hsl2rgb_pkg::ONE))
            light_dev = light2 - (hsl2rgb_pkg::UNIT_W + 1)'(hsl2rgb_pkg::ONE);
        else
            light_dev = (hsl2rgb_pkg::UNIT_W + 1)'(hsl2rgb_pkg::ONE) - light2;
        s1_span_next = hsl2rgb_pkg::UNIT_W'(hsl2rgb_pkg::ONE)
                     - light_dev[hsl2rgb_pkg::UNIT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s1_hue_reg   <= s1_hue_next;
            s1_sat_reg   <= s1_sat_next;
            s1_light_reg <= s1_light_next;
            s1_span_reg  <= s1_span_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: chroma multiply, and split the hue into sector and fraction.
    // ------------------------------------------------------------------------
    always_comb
    begin
        logic [2*hsl2rgb_pkg::UNIT_W-1:0] chroma_full;
        logic [hsl2rgb_pkg::HUE_W-1:0]    base;

        chroma_full    = (2 * hsl2rgb_pkg::UNIT_W)'(s1_span_reg)
                       * (2 * hsl2rgb_pkg::UNIT_W)'(s1_sat_reg);
        s2_chroma_next = chroma_full[hsl2rgb_pkg::FRAC_BITS +: hsl2rgb_pkg::UNIT_W];

        s2_sector_next = hsl2rgb_pkg::SECTOR_RED_YELLOW;
        base           = '0;
        for (int k = 1; k < 6; k++)
        begin
            if (s1_hue_reg >= hsl2rgb_pkg::HUE_W'(k * hsl2rgb_pkg::HUE_SECT))
            begin
                s2_sector_next = hsl2rgb_pkg::hue_sector_t'(k);
                base           = hsl2rgb_pkg::HUE_W'(k * hsl2rgb_pkg::HUE_SECT);
            end
        end
        s2_frac_next = hsl2rgb_pkg::F_W'(s1_hue_reg - base);
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            s2_sector_reg <= s2_sector_next;
            s2_frac_reg   <= s2_frac_next;
            s2_chroma_reg <= s2_chroma_next;
            s2_light_reg  <= s1_light_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: C times the rising or falling fraction; offset m = L - C/2.
    // ------------------------------------------------------------------------
    always_comb
    begin
        logic [hsl2rgb_pkg::SECT_W-1:0] ramp;

        if (s2_sector_reg[0])
            ramp = hsl2rgb_pkg::SECT_W'(hsl2rgb_pkg::HUE_SECT)
                 - hsl2rgb_pkg::SECT_W'(s2_frac_reg);
        else
            ramp = hsl2rgb_pkg::SECT_W'(s2_frac_reg);
        s3_prod_next   = hsl2rgb_pkg::PROD_W'(s2_chroma_reg)
                       * hsl2rgb_pkg::PROD_W'(ramp);
        s3_offset_next = s2_light_reg - (s2_chroma_reg >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (s3_move)
        begin
            s3_sector_reg <= s2_sector_reg;
            s3_prod_reg   <= s3_prod_next;
            s3_chroma_reg <= s2_chroma_reg;
            s3_offset_reg <= s3_offset_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: divide by one sector through an exact reciprocal multiply.
    // ------------------------------------------------------------------------
    always_comb
    begin
        logic [hsl2rgb_pkg::QPROD_W-1:0] qprod;

        qprod     = hsl2rgb_pkg::QPROD_W'(s3_prod_reg)
                  * hsl2rgb_pkg::QPROD_W'(hsl2rgb_pkg::RECIP);
        s4_x_next = qprod[hsl2rgb_pkg::RSH +: hsl2rgb_pkg::UNIT_W];
    end

    always_ff @(posedge clk)
    begin
        if (s4_move)
        begin
            s4_sector_reg <= s3_sector_reg;
            s4_x_reg      <= s4_x_next;
            s4_chroma_reg <= s3_chroma_reg;
            s4_offset_reg <= s3_offset_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: order (C, X, 0) by sector and add the offset.
    // ------------------------------------------------------------------------
    always_comb
    begin
        hsl2rgb_pkg::unit_t r_raw, g_raw, b_raw;

        case (s4_sector_reg)
            hsl2rgb_pkg::SECTOR_RED_YELLOW:
            begin
                r_raw = s4_chroma_reg; g_raw = s4_x_reg;      b_raw = '0;
            end
            hsl2rgb_pkg::SECTOR_YELLOW_GREEN:
            begin
                r_raw = s4_x_reg;      g_raw = s4_chroma_reg; b_raw = '0;
            end
            hsl2rgb_pkg::SECTOR_GREEN_CYAN:
            begin
                r_raw = '0;            g_raw = s4_chroma_reg; b_raw = s4_x_reg;
            end
            hsl2rgb_pkg::SECTOR_CYAN_BLUE:
            begin
                r_raw = '0;            g_raw = s4_x_reg;      b_raw = s4_chroma_reg;
            end
            hsl2rgb_pkg::SECTOR_BLUE_MAGENTA:
            begin
                r_raw = s4_x_reg;      g_raw = '0;            b_raw = s4_chroma_reg;
            end
            default:
            begin
                r_raw = s4_chroma_reg; g_raw = '0;            b_raw = s4_x_reg;
            end
        endcase

        // The sums never exceed one, so no saturation is needed.
        s5_red_next   = r_raw + s4_offset_reg;
        s5_green_next = g_raw + s4_offset_reg;
        s5_blue_next  = b_raw + s4_offset_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s5_move)
        begin
            s5_red_reg   <= s5_red_next;
            s5_green_reg <= s5_green_next;
            s5_blue_reg  <= s5_blue_next;
        end
    end

    assign rgb_valid = s5_valid_reg;
    assign red       = s5_red_reg;
    assign green     = s5_green_reg;
    assign blue      = s5_blue_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
    // The sector split never yields a code past the last sector.
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_sector_reg <= hsl2rgb_pkg::SECTOR_MAGENTA_RED))
        else $error("hue sector out of range");

    // The secondary component never exceeds the chroma.
    a_x_le_chroma: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (s4_x_reg <= s4_chroma_reg))
        else $error("secondary component larger than chroma");

    // Chroma plus offset stays within the unit range.
    a_sum_le_one: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (({1'b0, s4_chroma_reg} + {1'b0, s4_offset_reg})
                          <= (hsl2rgb_pkg::UNIT_W + 1)'(hsl2rgb_pkg::ONE)))
        else $error("chroma plus offset exceeds one");

    // A full pipeline under an output stall pushes back on the input.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg
         && s5_valid_reg && rgb_stall) |-> hsl_stall)
        else $error("full pipeline took an item under stall");
`endif

endmodule

// File: tb/hsl_to_rgb_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// HSL to RGB conversion checker
// Watches both channels of the converter, predicts the RGB color of every
// accepted HSL item and compares each returned color with the oldest
// prediction in flight.
// ============================================================================
module hsl_to_rgb_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                hsl_valid,
    input  logic                                hsl_stall,
    input  logic signed [hsl2rgb_pkg::IN_W-1:0] hue,
    input  logic signed [hsl2rgb_pkg::IN_W-1:0] saturation,
    input  logic signed [hsl2rgb_pkg::IN_W-1:0] lightness,
    input  logic                                rgb_valid,
    input  logic                                rgb_stall,
    input  logic [hsl2rgb_pkg::UNIT_W-1:0]      red,
    input  logic [hsl2rgb_pkg::UNIT_W-1:0]      green,
    input  logic [hsl2rgb_pkg::UNIT_W-1:0]      blue,
    output int                                  mismatch_count,
    output int                                  colors_pending
);

    typedef struct packed {
        hsl2rgb_pkg::unit_t red;
        hsl2rgb_pkg::unit_t green;
        hsl2rgb_pkg::unit_t blue;
    } rgb_color_t;

    // Colors predicted for items that are still inside the converter.
    rgb_color_t expected_colors[$];

    // Limits a level to the unit range 0..ONE.
    function automatic int clamp_to_unit(input int level);
        if (level < 0)
            return 0;
        if (level > hsl2rgb_pkg::ONE)
            return hsl2rgb_pkg::ONE;
        return level;
    endfunction

    // Integer HSL to RGB conversion at the converter's formats.
    function automatic rgb_color_t predict_rgb(
        input logic signed [hsl2rgb_pkg::IN_W-1:0] hue_in,
        input logic signed [hsl2rgb_pkg::IN_W-1:0] sat_in,
        input logic signed [hsl2rgb_pkg::IN_W-1:0] light_in);
        int         angle;
        int         sat;
        int         light;
        int         light_dev;
        int         chroma;
        int         sector_idx;
        int         frac;
        int         second;
        int         offset;
        int         r;
        int         g;
        int         b;
        rgb_color_t color;

        // Wrap the hue into one turn with a true modulo.
        angle = int'(hue_in) % hsl2rgb_pkg::HUE_FULL;
        if (angle < 0)
            angle += hsl2rgb_pkg::HUE_FULL;
        sat   = clamp_to_unit(int'(sat_in));
        light = clamp_to_unit(int'(light_in));

        // Chroma from the distance of lightness to one half.
        light_dev = 2 * light - hsl2rgb_pkg::ONE;
        if (light_dev < 0)
            light_dev = -light_dev;
        chroma = ((hsl2rgb_pkg::ONE - light_dev) * sat) >>> hsl2rgb_pkg::FRAC_BITS;

        // Secondary component rises in even sectors and falls in odd ones.
        sector_idx = angle / hsl2rgb_pkg::HUE_SECT;
        frac       = angle % hsl2rgb_pkg::HUE_SECT;
        if (sector_idx % 2 == 1)
            second = (chroma * (hsl2rgb_pkg::HUE_SECT - frac)) / hsl2rgb_pkg::HUE_SECT;
        else
            second = (chroma * frac) / hsl2rgb_pkg::HUE_SECT;

        case (hsl2rgb_pkg::hue_sector_t'(sector_idx))
            hsl2rgb_pkg::SECTOR_RED_YELLOW:
                begin r = chroma; g = second; b = 0;      end
            hsl2rgb_pkg::SECTOR_YELLOW_GREEN:
                begin r = second; g = chroma; b = 0;      end
            hsl2rgb_pkg::SECTOR_GREEN_CYAN:
                begin r = 0;      g = chroma; b = second; end
            hsl2rgb_pkg::SECTOR_CYAN_BLUE:
                begin r = 0;      g = second; b = chroma; end
            hsl2rgb_pkg::SECTOR_BLUE_MAGENTA:
                begin r = second; g = 0;      b = chroma; end
            default:
                begin r = chroma; g = 0;      b = second; end
        endcase

        offset      = light - (chroma >>> 1);
        color.red   = hsl2rgb_pkg::unit_t'(clamp_to_unit(r + offset));
        color.green = hsl2rgb_pkg::unit_t'(clamp_to_unit(g + offset));
        color.blue  = hsl2rgb_pkg::unit_t'(clamp_to_unit(b + offset));
        return color;
    endfunction

    // Compare returned colors first, then record the item taken at this edge.
    always @(posedge clk or negedge rst_n)
    begin
        int         new_fails;
        int         delta;
        rgb_color_t want;

        if (!rst_n)
        begin
            expected_colors.delete();
            mismatch_count <= 0;
            colors_pending <= 0;
        end
        else
        begin
            new_fails = 0;
            delta     = 0;
            if (rgb_valid && !rgb_stall)
            begin
                if (expected_colors.size() == 0)
                begin
                    new_fails = 1;
                    if (mismatch_count < 10)
                        $display("%0t: unexpected color r=%0d g=%0d b=%0d",
                                 $time, red, green, blue);
                end
                else
                begin
                    want  = expected_colors.pop_front();
                    delta = delta - 1;
                    if (want.red !== red || want.green !== green || want.blue !== blue)
                    begin
                        new_fails = 1;
                        if (mismatch_count < 10)
                            $display({"%0t: color mismatch exp r=%0d g=%0d b=%0d,",
                                      " got r=%0d g=%0d b=%0d"},
                                     $time, want.red, want.green, want.blue,
                                     red, green, blue);
                    end
                end
            end
            if (hsl_valid && !hsl_stall)
            begin
                expected_colors.push_back(predict_rgb(hue, saturation, lightness));
                delta = delta + 1;
            end
            mismatch_count <= mismatch_count + new_fails;
            colors_pending <= colors_pending + delta;
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// HSL to RGB converter testbench
// Feeds directed corner colors and then random HSL items through the
// converter under three patterns of sender idling and receiver stalls, and
// takes the verdict from the checker that runs beside the converter.
// ============================================================================
module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 134;

    logic                                clk;
    logic                                rst_n           = 1'b0;
    logic                                hsl_valid       = 1'b0;
    logic                                hsl_stall;
    logic signed [hsl2rgb_pkg::IN_W-1:0] hue             = '0;
    logic signed [hsl2rgb_pkg::IN_W-1:0] saturation      = '0;
    logic signed [hsl2rgb_pkg::IN_W-1:0] lightness       = '0;
    logic                                rgb_valid;
    logic                                rgb_stall       = 1'b0;
    logic [hsl2rgb_pkg::UNIT_W-1:0]      red;
    logic [hsl2rgb_pkg::UNIT_W-1:0]      green;
    logic [hsl2rgb_pkg::UNIT_W-1:0]      blue;
    int                                  mismatch_count;
    int                                  colors_pending;
    int                                  send_idle_pct   = 0;
    int                                  recv_stall_pct  = 0;
    int                                  quiet_cycles    = 0;

    hsl_to_rgb_converter u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .hsl_valid  (hsl_valid),
        .hsl_stall  (hsl_stall),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .rgb_valid  (rgb_valid),
        .rgb_stall  (rgb_stall),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    hsl_to_rgb_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .hsl_valid      (hsl_valid),
        .hsl_stall      (hsl_stall),
        .hue            (hue),
        .saturation     (saturation),
        .lightness      (lightness),
        .rgb_valid      (rgb_valid),
        .rgb_stall      (rgb_stall),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .mismatch_count (mismatch_count),
        .colors_pending (colors_pending)
    );

    // Free-running clock, 20 ns period.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver stalls at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        rgb_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Ends the run when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((hsl_valid && !hsl_stall) || (rgb_valid && !rgb_stall))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("FAIL hsl_to_rgb_converter");
            $finish;
        end
    end

    // Offers one HSL item, idling first at random, and holds it until taken.
    task automatic send_hsl(input logic signed [hsl2rgb_pkg::IN_W-1:0] h,
                            input logic signed [hsl2rgb_pkg::IN_W-1:0] s,
                            input logic signed [hsl2rgb_pkg::IN_W-1:0] l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            hsl_valid <= 1'b0;
            @(posedge clk);
        end
        hsl_valid  <= 1'b1;
        hue        <= h;
        saturation <= s;
        lightness  <= l;
        do
            @(posedge clk);
        while (hsl_stall);
    endtask

    // Stops offering and waits until every predicted color has come back.
    task automatic drain_colors();
        hsl_valid <= 1'b0;
        do
            @(posedge clk);
        while (colors_pending != 0);
    endtask

    // Saturation or lightness: mostly in range, sometimes out of it.
    function automatic logic signed [hsl2rgb_pkg::IN_W-1:0] pick_level();
        int pick;
        pick = $urandom_range(9);
        if (pick < 7)
            return hsl2rgb_pkg::IN_W'($urandom_range(0, hsl2rgb_pkg::ONE));
        if (pick == 7)
            return hsl2rgb_pkg::IN_W'($urandom_range(hsl2rgb_pkg::ONE + 1, 8191));
        if (pick == 8)
            return hsl2rgb_pkg::IN_W'(-1 - int'($urandom_range(0, 8191)));
        return hsl2rgb_pkg::IN_W'($urandom());
    endfunction

    // Hue: any pattern, or one next to a sector border of some turn.
    function automatic logic signed [hsl2rgb_pkg::IN_W-1:0] pick_hue();
        int border;
        if ($urandom_range(3) == 0)
        begin
            border = int'($urandom_range(0, 12)) * hsl2rgb_pkg::HUE_SECT
                   - hsl2rgb_pkg::HUE_FULL;
            return hsl2rgb_pkg::IN_W'(border + int'($urandom_range(0, 2)) - 1);
        end
        return hsl2rgb_pkg::IN_W'($urandom());
    endfunction

    // Stimulus and verdict.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 30; recv_stall_pct <= 81; end
                1:       begin send_idle_pct = 81; recv_stall_pct <= 30; end
                default: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            endcase

            if (phase == 0)
            begin
                // Hue extremes, wrap points and sector borders.
                send_hsl(-14'sd8192, 14'sd4096, 14'sd2048);
                send_hsl(14'sd8191, 14'sd4096, 14'sd2048);
                send_hsl(-14'sd5760, 14'sd4096, 14'sd2048);
                send_hsl(-14'sd5761, 14'sd4096, 14'sd2048);
                send_hsl(14'sd5759, 14'sd4096, 14'sd2048);
                send_hsl(14'sd5760, 14'sd4096, 14'sd2048);
                send_hsl(14'sd0, 14'sd4096, 14'sd2048);
                send_hsl(-14'sd1, 14'sd4096, 14'sd2048);
                send_hsl(14'sd959, 14'sd4096, 14'sd2048);
                send_hsl(14'sd960, 14'sd4096, 14'sd2048);
                send_hsl(14'sd1920, 14'sd4096, 14'sd2048);
                send_hsl(14'sd2880, 14'sd4096, 14'sd2048);
                send_hsl(14'sd3840, 14'sd4096, 14'sd2048);
                send_hsl(14'sd4800, 14'sd3000, 14'sd1500);
                // Saturation and lightness clamping at both ends.
                send_hsl(14'sd500, -14'sd8192, 14'sd2048);
                send_hsl(14'sd500, 14'sd8191, 14'sd2048);
                send_hsl(14'sd500, 14'sd4097, 14'sd4097);
                send_hsl(14'sd500, -14'sd1, -14'sd1);
                send_hsl(14'sd1500, 14'sd4096, 14'sd0);
                send_hsl(14'sd1500, 14'sd4096, 14'sd4096);
                send_hsl(14'sd1500, 14'sd4096, 14'sd8191);
                send_hsl(14'sd1500, 14'sd4096, -14'sd8192);
                send_hsl(14'sd2500, 14'sd0, 14'sd3000);
                send_hsl(14'sd3500, 14'sd2048, 14'sd2047);
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_hsl(pick_hue(), pick_level(), pick_level());

            // Hold off until the converter has returned every color.
            drain_colors();
        end

        // Let any stray color show up after the last expected one.
        repeat (20) @(posedge clk);

        if (colors_pending != 0)
            $display("%0d expected colors never arrived", colors_pending);
        if (mismatch_count == 0 && colors_pending == 0)
            $display("PASS hsl_to_rgb_converter");
        else
            $display("FAIL hsl_to_rgb_converter");
        $finish;
    end

endmodule
